// ===== rtl/dup_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dup_pkg
// Shared types, character codes and lookup functions of the data URL
// payload decoder.
// ----------------------------------------------------------------------------
package dup_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    kind_t      kind;
  } res_t;

  // Escape sequencer phases
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_ONE  = 2'd1;
  localparam logic [1:0] ESC_TWO  = 2'd2;

  localparam logic [15:0] CH_PERCENT = 16'h0025;
  localparam logic [15:0] CH_EQUALS  = 16'h003d;
  localparam logic [15:0] CH_SPACE   = 16'h0020;
  localparam logic [15:0] CH_TAB     = 16'h0009;
  localparam logic [15:0] CH_CR      = 16'h000d;
  localparam logic [15:0] CH_PLUS    = 16'h002b;
  localparam logic [15:0] CH_SLASH   = 16'h002f;

  localparam logic signed [3:0] BITCNT_RESET = -4'sd8;

  // {valid, six-bit value} of a base64 alphabet character
  function automatic logic [6:0] sixbit_of(input logic [15:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 16'h0041 && c <= 16'h005a) begin
      r = {1'b1, 6'(c - 16'd65)};
    end else if (c >= 16'h0061 && c <= 16'h007a) begin
      r = {1'b1, 6'(c - 16'd71)};
    end else if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, 6'(c + 16'd4)};
    end else if (c == CH_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (c == CH_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // {valid, nibble} of a hex digit
  function automatic logic [4:0] nibble_of(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, 4'(c - 16'd48)};
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      r = {1'b1, 4'(c - 16'd87)};
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      r = {1'b1, 4'(c - 16'd55)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dup_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dup_in_if
// Character channel: one payload character and its end-of-payload flag.
// ----------------------------------------------------------------------------
interface dup_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] character;
  logic        last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/dup_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dup_out_if
// Result channel: decoded byte or end/error status.
// ----------------------------------------------------------------------------
interface dup_out_if
  import dup_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  kind_t      kind;
  logic       last_of_run;

  modport source (output valid, byte_value, kind, last_of_run, input ready);
  modport sink   (input valid, byte_value, kind, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/data_url_payload_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// data_url_payload_decoder
// Decodes data URL payload characters (base64 or percent escapes) to bytes.
// ----------------------------------------------------------------------------
// One character is taken per transaction on in_ch, with last set on the
// final character of a payload. cfg_wdata written under cfg_we selects the
// decoding (0 percent escapes with literal pass-through, 1 base64); write it
// only while the block is idle. Each character is decoded in the cycle it is
// accepted and its zero to three results are loaded into a three-slot result
// bundle that drains one transaction per cycle on out_ch while out_ch is ready;
// last_of_run marks the final result of a character. A new character is taken
// every cycle as long as each character yields at most one result and out_ch
// takes it; a character that yields more results holds off the input until
// its bundle is down to its final result and out_ch takes that. The end of a
// payload reports success, or failure when no byte came out; a bad character
// reports an error, after which characters are dropped until the last one.
// ----------------------------------------------------------------------------
module data_url_payload_decoder
  import dup_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  dup_in_if.sink     in_ch,
  dup_out_if.source  out_ch
);

  // Decoder state
  logic                mode_r;
  logic [13:0]         bit_buffer_r,     bit_buffer_nxt;
  logic signed [3:0]   bit_count_r,      bit_count_nxt;
  logic [1:0]          escape_phase_r,   escape_phase_nxt;
  logic [3:0]          held_nibble_r,    held_nibble_nxt;
  logic                held_nibble_ok_r, held_nibble_ok_nxt;
  logic                any_byte_out_r,   any_byte_out_nxt;
  logic                swallowing_r,     swallowing_nxt;

  // Result bundle: slot 0 is the head
  res_t                slot_r [3];
  res_t                slot_nxt [3];
  logic [1:0]          cnt_r, cnt_nxt;
  logic [1:0]          n_new;

  logic                accept;
  logic                pop;
  logic                ok;
  logic                space;
  logic [6:0]          sx;
  logic [4:0]          nb;
  logic signed [3:0]   cnt_sum;
  logic [13:0]         shifted;
  logic [15:0]         c;
  logic                lst;
  res_t                new_slot [3];

  assign pop    = out_ch.valid && out_ch.ready;
  // Take a character once the bundle is empty or about to be
  assign in_ch.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.byte_value  = slot_r[0].byte_value;
  assign out_ch.kind        = slot_r[0].kind;
  assign out_ch.last_of_run = (cnt_r == 2'd1);

  assign c   = in_ch.character;
  assign lst = in_ch.last;

  // Per-character decode: state update and result list
  always_comb begin
    bit_buffer_nxt     = bit_buffer_r;
    bit_count_nxt      = bit_count_r;
    escape_phase_nxt   = escape_phase_r;
    held_nibble_nxt    = held_nibble_r;
    held_nibble_ok_nxt = held_nibble_ok_r;
    any_byte_out_nxt   = any_byte_out_r;
    swallowing_nxt     = swallowing_r;
    n_new              = 2'd0;
    ok                 = 1'b1;
    space              = (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
    sx                 = sixbit_of(c);
    nb                 = nibble_of(c);
    cnt_sum            = bit_count_r + 4'sd6;
    shifted            = '0;
    for (int i = 0; i < 3; i++) begin
      new_slot[i] = '{byte_value: 8'd0, kind: KIND_DATA};
    end

    if (!swallowing_r) begin
      if (mode_r) begin
        // Base64: skip padding and white space
        if (!(c == CH_EQUALS || space)) begin
          if (!sx[6]) begin
            new_slot[n_new] = '{byte_value: 8'd0, kind: KIND_ERROR};
            n_new = n_new + 2'd1;
            ok = 1'b0;
          end else begin
            bit_buffer_nxt = {bit_buffer_r[7:0], sx[5:0]};
            bit_count_nxt  = cnt_sum;
            if (!cnt_sum[3]) begin
              shifted = bit_buffer_nxt >> cnt_sum[2:0];
              new_slot[n_new] = '{byte_value: shifted[7:0], kind: KIND_DATA};
              n_new = n_new + 2'd1;
              any_byte_out_nxt = 1'b1;
              // Subtract eight: the count is 0..4 here
              bit_count_nxt = {1'b1, cnt_sum[2:0]};
            end
          end
        end
      end else begin
        case (escape_phase_r)
          ESC_ONE: begin
            if (lst) begin
              // Escape cut short by the end: literal '%' then the character
              new_slot[n_new] = '{byte_value: CH_PERCENT[7:0], kind: KIND_DATA};
              n_new = n_new + 2'd1;
              any_byte_out_nxt = 1'b1;
              escape_phase_nxt = ESC_NONE;
              if (c[15:8] == 8'd0) begin
                new_slot[n_new] = '{byte_value: c[7:0], kind: KIND_DATA};
                n_new = n_new + 2'd1;
              end else begin
                new_slot[n_new] = '{byte_value: 8'd0, kind: KIND_ERROR};
                n_new = n_new + 2'd1;
                ok = 1'b0;
              end
            end else begin
              held_nibble_nxt    = nb[3:0];
              held_nibble_ok_nxt = nb[4];
              escape_phase_nxt   = ESC_TWO;
            end
          end
          ESC_TWO: begin
            escape_phase_nxt = ESC_NONE;
            if (held_nibble_ok_r && nb[4]) begin
              new_slot[n_new] = '{byte_value: {held_nibble_r, nb[3:0]}, kind: KIND_DATA};
              n_new = n_new + 2'd1;
              any_byte_out_nxt = 1'b1;
            end else begin
              new_slot[n_new] = '{byte_value: 8'd0, kind: KIND_ERROR};
              n_new = n_new + 2'd1;
              ok = 1'b0;
            end
          end
          default: begin
            if (c == CH_PERCENT && !lst) begin
              escape_phase_nxt = ESC_ONE;
            end else if (c[15:8] == 8'd0) begin
              new_slot[n_new] = '{byte_value: c[7:0], kind: KIND_DATA};
              n_new = n_new + 2'd1;
              any_byte_out_nxt = 1'b1;
            end else begin
              new_slot[n_new] = '{byte_value: 8'd0, kind: KIND_ERROR};
              n_new = n_new + 2'd1;
              ok = 1'b0;
            end
          end
        endcase
      end

      // End report
      if (ok && lst) begin
        new_slot[n_new] = '{byte_value: 8'd0,
                            kind: any_byte_out_nxt ? KIND_OK : KIND_EMPTY};
        n_new = n_new + 2'd1;
      end
      if (!ok) begin
        swallowing_nxt = 1'b1;
      end
    end

    // Restart the stream on every last character
    if (lst) begin
      bit_buffer_nxt     = '0;
      bit_count_nxt      = BITCNT_RESET;
      escape_phase_nxt   = ESC_NONE;
      held_nibble_nxt    = '0;
      held_nibble_ok_nxt = 1'b0;
      any_byte_out_nxt   = 1'b0;
      swallowing_nxt     = 1'b0;
    end
  end

  // Bundle load and drain
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < 3; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (accept) begin
      cnt_nxt = n_new;
      for (int i = 0; i < 3; i++) begin
        slot_nxt[i] = new_slot[i];
      end
    end else if (pop) begin
      // Advance the head
      cnt_nxt     = cnt_r - 2'd1;
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= 1'b0;
      bit_buffer_r     <= '0;
      bit_count_r      <= BITCNT_RESET;
      escape_phase_r   <= ESC_NONE;
      held_nibble_r    <= '0;
      held_nibble_ok_r <= 1'b0;
      any_byte_out_r   <= 1'b0;
      swallowing_r     <= 1'b0;
      cnt_r            <= 2'd0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        bit_buffer_r     <= bit_buffer_nxt;
        bit_count_r      <= bit_count_nxt;
        escape_phase_r   <= escape_phase_nxt;
        held_nibble_r    <= held_nibble_nxt;
        held_nibble_ok_r <= held_nibble_ok_nxt;
        any_byte_out_r   <= any_byte_out_nxt;
        swallowing_r     <= swallowing_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Payload slots hold without reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  // An error closes the results of its character
  a_error_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_ERROR) |-> out_ch.last_of_run)
    else $error("error result not marked last of run");

  // An end report closes the results of its character
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == KIND_OK || out_ch.kind == KIND_EMPTY))
      |-> out_ch.last_of_run)
    else $error("end report not marked last of run");

  // A last character restarts the stream state
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last) |=>
      (escape_phase_r == ESC_NONE && bit_count_r == BITCNT_RESET &&
       !swallowing_r && !any_byte_out_r))
    else $error("stream state not restarted after last character");

  // Nothing is emitted for a dropped character
  a_swallow_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && swallowing_r) |=> (cnt_r == 2'd0))
    else $error("result produced while dropping characters");

endmodule
`default_nettype wire

// ===== sim/data_url_payload_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// data_url_payload_decoder_tb
// Self-checking bench for the data URL payload decoder.
// ----------------------------------------------------------------------------
// A short table of directed characters covers:
//   - byte extremes and percent escapes;
//   - bad escapes, wide characters, and a percent sign near the end;
//   - base64 padding and white space, errors and the empty-stream report;
//   - a mode switch in the middle of a stream.
// Random streams follow, mostly well formed with random content, under four
// handshake phases:
//   - no idling;
//   - an idle sender;
//   - a stalling receiver;
//   - both idling.
// A long receiver hold-off backs the block up into its input. Every result
// transaction is checked field by field against the table or an in-bench decoder.
// ----------------------------------------------------------------------------
module data_url_payload_decoder_tb;
  import dup_pkg::*;

  localparam int DRAIN_CYCLES = 8;     // quiet cycles before a mode write / end
  localparam int HOLD_CYCLES  = 40;    // long receiver hold-off
  localparam int PHASE_ITEMS  = 20;    // counted characters per random phase
  localparam int DIR_ROWS     = 28;

  // One result transaction as the block should present it
  typedef struct packed {
    logic [7:0] byte_value;
    kind_t      kind;
    logic       last_of_run;
  } outcome_t;

  // One directed character; typed rows carry their results, others are decoded
  typedef struct packed {
    logic        mode;
    logic [15:0] ch;
    logic        last;
    logic        typed;
    logic [1:0]  n_typed;
    outcome_t    t0;
    outcome_t    t1;
  } step_row_t;

  localparam outcome_t NO_OUT = '{8'h00, KIND_DATA, 1'b0};

  // mode, character, last, typed, count, first result, second result
  localparam step_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
    // percent mode: literal byte then the success report
    '{1'b0, 16'h0041, 1'b1, 1'b1, 2'd2, '{8'h41, KIND_DATA, 1'b0}, '{8'h00, KIND_OK, 1'b1}},
    // byte extremes pass through
    '{1'b0, 16'h0000, 1'b0, 1'b1, 2'd1, '{8'h00, KIND_DATA, 1'b1}, NO_OUT},
    '{1'b0, 16'h00ff, 1'b0, 1'b1, 2'd1, '{8'hff, KIND_DATA, 1'b1}, NO_OUT},
    // escape with mixed-case hex digits
    '{1'b0, 16'h0025, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0046, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0066, 1'b0, 1'b1, 2'd1, '{8'hff, KIND_DATA, 1'b1}, NO_OUT},
    // bad first hex digit, then drop until the last character
    '{1'b0, 16'h0025, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0047, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0030, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0071, 1'b1, 1'b1, 2'd0, NO_OUT, NO_OUT},
    // percent sign as the last character is a literal
    '{1'b0, 16'h0025, 1'b1, 1'b1, 2'd2, '{8'h25, KIND_DATA, 1'b0}, '{8'h00, KIND_OK, 1'b1}},
    // percent sign before a wide last character
    '{1'b0, 16'h0025, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0100, 1'b1, 1'b0, 2'd0, NO_OUT, NO_OUT},
    // wide character on the last item: error, no end report
    '{1'b0, 16'h0100, 1'b1, 1'b1, 2'd1, '{8'h00, KIND_ERROR, 1'b1}, NO_OUT},
    // percent sign whose next character is the last
    '{1'b0, 16'h0025, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0042, 1'b1, 1'b0, 2'd0, NO_OUT, NO_OUT},
    // base64 with white space at both ends of the control range
    '{1'b1, 16'h0054, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b1, 16'h0057, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b1, 16'h0009, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b1, 16'h0046, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b1, 16'h000d, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b1, 16'h003d, 1'b1, 1'b0, 2'd0, NO_OUT, NO_OUT},
    // padding alone, and leftover bits only: no bytes came out
    '{1'b1, 16'h003d, 1'b1, 1'b1, 2'd1, '{8'h00, KIND_EMPTY, 1'b1}, NO_OUT},
    '{1'b1, 16'h0041, 1'b1, 1'b1, 2'd1, '{8'h00, KIND_EMPTY, 1'b1}, NO_OUT},
    // control character just below white space is outside the alphabet
    '{1'b1, 16'h0008, 1'b0, 1'b1, 2'd1, '{8'h00, KIND_ERROR, 1'b1}, NO_OUT},
    '{1'b1, 16'h007a, 1'b1, 1'b1, 2'd0, NO_OUT, NO_OUT},
    // switch to percent mode in the middle of a stream
    '{1'b1, 16'h0051, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT},
    '{1'b0, 16'h0078, 1'b1, 1'b0, 2'd0, NO_OUT, NO_OUT}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dup_in_if  in_bus ();
  dup_out_if out_bus ();

  data_url_payload_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // Decoder state of the bench, mirrors what the block should hold
  logic        cur_mode;
  logic [13:0] acc_bits;
  int          acc_count;
  logic [1:0]  esc_state;
  logic [3:0]  hi_nibble;
  logic        hi_nibble_ok;
  logic        seen_byte;
  logic        dropping;

  outcome_t    char_decodes [$];   // results of the character just taken
  outcome_t    due_decodes [$];    // results the block still owes
  logic [15:0] stream_chars [$];   // random stream under construction

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_asked;
  int fail_count;

  // ---------------------------------------------------------------------------
  // In-bench decoder
  // ---------------------------------------------------------------------------
  function automatic void restart_stream();
    acc_bits     = '0;
    acc_count    = -8;
    esc_state    = ESC_NONE;
    hi_nibble    = '0;
    hi_nibble_ok = 1'b0;
    seen_byte    = 1'b0;
    dropping     = 1'b0;
  endfunction

  // Append to the queues at their tail
  function automatic void queue_char(input logic [15:0] c);
    stream_chars.insert(stream_chars.size(), c);
  endfunction

  function automatic void owe_result(input outcome_t o);
    due_decodes.insert(due_decodes.size(), o);
  endfunction

  function automatic void add_outcome(input logic [7:0] b, input kind_t k);
    outcome_t o;
    o = '{b, k, 1'b0};
    char_decodes.insert(char_decodes.size(), o);
    if (k == KIND_DATA) seen_byte = 1'b1;
  endfunction

  function automatic int b64_value(input logic [15:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - 65;
    if (c >= "a" && c <= "z") return int'(c) - 97 + 26;
    if (c >= "0" && c <= "9") return int'(c) - 48 + 52;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    return -1;
  endfunction

  function automatic int hex_value(input logic [15:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 97 + 10;
    if (c >= "A" && c <= "F") return int'(c) - 65 + 10;
    return -1;
  endfunction

  // Pass a plain character through; wider than a byte is an error
  function automatic logic pass_plain(input logic [15:0] c);
    if (c <= 16'h00ff) begin
      add_outcome(c[7:0], KIND_DATA);
      return 1'b1;
    end
    add_outcome(8'h00, KIND_ERROR);
    return 1'b0;
  endfunction

  // Decode one accepted character into char_decodes and advance the state
  function automatic void decode_char(input logic [15:0] c, input logic last);
    logic     ok;
    int       v;
    outcome_t tail;
    char_decodes.delete();
    ok = 1'b1;
    if (dropping) begin
      if (last) restart_stream();
      return;
    end
    if (cur_mode) begin
      if (!(c == CH_EQUALS || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
        v = b64_value(c);
        if (v < 0) begin
          add_outcome(8'h00, KIND_ERROR);
          ok = 1'b0;
        end else begin
          acc_bits  = {acc_bits[7:0], 6'(v)};
          acc_count = acc_count + 6;
          if (acc_count >= 0) begin
            add_outcome(8'(acc_bits >> acc_count), KIND_DATA);
            acc_count = acc_count - 8;
          end
        end
      end
    end else if (esc_state == ESC_ONE) begin
      if (last) begin
        // too near the end to be an escape
        add_outcome(8'(CH_PERCENT), KIND_DATA);
        esc_state = ESC_NONE;
        ok = pass_plain(c);
      end else begin
        v = hex_value(c);
        hi_nibble    = (v < 0) ? 4'h0 : 4'(v);
        hi_nibble_ok = (v >= 0);
        esc_state    = ESC_TWO;
      end
    end else if (esc_state == ESC_TWO) begin
      v = hex_value(c);
      esc_state = ESC_NONE;
      if (hi_nibble_ok && v >= 0) begin
        add_outcome({hi_nibble, 4'(v)}, KIND_DATA);
      end else begin
        add_outcome(8'h00, KIND_ERROR);
        ok = 1'b0;
      end
    end else if (c == CH_PERCENT && !last) begin
      esc_state = ESC_ONE;
    end else begin
      ok = pass_plain(c);
    end

    if (ok && last) add_outcome(8'h00, seen_byte ? KIND_OK : KIND_EMPTY);
    if (last) restart_stream();
    else if (!ok) dropping = 1'b1;

    if (char_decodes.size() > 0) begin
      tail = char_decodes[char_decodes.size() - 1];
      tail.last_of_run = 1'b1;
      char_decodes[char_decodes.size() - 1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random stream content
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] b64_char(input int idx);
    if (idx < 26) return 16'(65 + idx);
    if (idx < 52) return 16'(97 + idx - 26);
    if (idx < 62) return 16'(48 + idx - 52);
    return (idx == 62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [15:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 16'(48 + v);
    return $urandom_range(0, 1) ? 16'(97 + v - 10) : 16'(65 + v - 10);
  endfunction

  function automatic logic [15:0] pad_or_space();
    int r;
    r = $urandom_range(0, 6);
    if (r < 5) return CH_TAB + 16'(r);
    return (r == 5) ? CH_SPACE : CH_EQUALS;
  endfunction

  // Build one stream: mostly well formed, with some broken characters
  function automatic void make_stream(input logic b64);
    int len;
    int pick;
    stream_chars.delete();
    len = $urandom_range(1, 8);
    while (stream_chars.size() < len) begin
      pick = $urandom_range(0, 99);
      if (b64) begin
        if (pick < 80) queue_char(b64_char($urandom_range(0, 63)));
        else if (pick < 93) queue_char(pad_or_space());
        else queue_char(16'($urandom_range(0, 65535)));
      end else if (pick < 45) begin
        queue_char(16'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        queue_char(CH_PERCENT);
        queue_char(hex_char());
        queue_char(hex_char());
      end else if (pick < 92) begin
        // escape with a likely bad digit in either place
        queue_char(CH_PERCENT);
        if ($urandom_range(0, 1)) begin
          queue_char(16'($urandom_range(0, 127)));
          queue_char(hex_char());
        end else begin
          queue_char(hex_char());
          queue_char(16'($urandom_range(0, 127)));
        end
      end else begin
        queue_char(16'($urandom_range(0, 65535)));
      end
    end
    // end some percent streams with a dangling escape
    if (!b64) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_char(CH_PERCENT);
      end else if (pick == 1) begin
        queue_char(CH_PERCENT);
        queue_char(16'($urandom_range(0, 255)));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: decide ready at the rising edge, drive it at the falling edge.
  // A hold-off request stalls the output for a long stretch counted here.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int   hold_left;
    int   hold_served;
    logic next_ready;
    hold_left      = 0;
    hold_served    = 0;
    out_bus.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
      @(negedge clk);
      out_bus.ready = next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each result transaction with the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_decodes.size() == 0) begin
        $error("unowed result: byte_value %02h kind %0d last_of_run %0d",
               out_bus.byte_value, out_bus.kind, out_bus.last_of_run);
        fail_count++;
      end else begin
        want = due_decodes.pop_front();
        if (out_bus.byte_value !== want.byte_value) begin
          $error("byte_value: expected %02h, got %02h", want.byte_value, out_bus.byte_value);
          fail_count++;
        end
        if (out_bus.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
          fail_count++;
        end
        if (out_bus.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                 out_bus.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. Each is entered and left just after a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one character, wait for its transaction, then record what it owes.
  // Valid stays high on return so back-to-back characters leave no bubble.
  task automatic send_item(input step_row_t row);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.character = row.ch;
    in_bus.last      = row.last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    // accepted at this edge: advance the bench decoder
    decode_char(row.ch, row.last);
    if (row.typed) begin
      if (row.n_typed >= 2'd1) owe_result(row.t0);
      if (row.n_typed >= 2'd2) owe_result(row.t1);
    end else begin
      foreach (char_decodes[k]) owe_result(char_decodes[k]);
    end
    @(negedge clk);
  endtask

  // Drop valid, wait until every owed result is out, then let the block settle
  task automatic settle();
    in_bus.valid = 1'b0;
    while (due_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_decode_mode(input logic m);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_mode  = m;
  endtask

  // Random streams under one handshake setting; dropped characters are not counted
  task automatic run_phase(input int idle_pct, input int stall_pct, input logic squeeze);
    int        taken;
    int        i;
    logic      squeeze_due;
    step_row_t row;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    taken       = 0;
    squeeze_due = squeeze;
    while (taken < PHASE_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_decode_mode(1'($urandom_range(0, 1)));
      make_stream(cur_mode);
      for (i = 0; i < stream_chars.size(); i++) begin
        // now and then flip the mode in the middle of a stream
        if (i > 0 && $urandom_range(0, 24) == 0) write_decode_mode(!cur_mode);
        // hold off the output while the sender keeps offering characters
        if (squeeze_due) begin
          hold_asked++;
          squeeze_due = 1'b0;
        end
        if (!dropping) taken++;
        row      = '0;
        row.ch   = stream_chars[i];
        row.last = (i == stream_chars.size() - 1);
        send_item(row);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    step_row_t row;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.character   = '0;
    in_bus.last        = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_asked         = 0;
    fail_count         = 0;
    cur_mode           = 1'b0;
    restart_stream();

    // hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // walk the directed table; switch mode only with the block drained
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.mode != cur_mode) write_decode_mode(row.mode);
      send_item(row);
    end

    // random streams: no idling with a long output hold-off, idle sender,
    // stalling receiver, then both
    run_phase(0, 0, 1'b1);
    run_phase(85, 0, 1'b0);
    run_phase(0, 85, 1'b0);
    run_phase(34, 34, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
